@@ rtl/core/ctb_pkg.sv @@
// ----------------------------------------------------------------------------
// ctb_pkg
// shared constants and types of the cursor text buffer
// ----------------------------------------------------------------------------
package ctb_pkg;

   localparam int CAPACITY_DEF = 4096;
   localparam int WINDOW_DEF   = 10;

   localparam int OPCODE_W = 2;
   localparam int CHAR_W   = 8;
   localparam int STEP_W   = 13;
   localparam int KIND_W   = 2;

   typedef enum logic [OPCODE_W-1:0] {
      OP_INSERT    = 2'd0,
      OP_BACKSPACE = 2'd1,
      OP_LEFT      = 2'd2,
      OP_RIGHT     = 2'd3
   } opcode_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_DELETE = 2'd0,
      KIND_CHAR   = 2'd1,
      KIND_FULL   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MOVE,
      ST_WINDOW
   } state_type;

endpackage

@@ rtl/core/ctb_ram.sv @@
// ----------------------------------------------------------------------------
// ctb_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module ctb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/core/cursor_text_buffer_top.sv @@
// ----------------------------------------------------------------------------
// cursor_text_buffer_top
// text buffer with a cursor, kept as a gap buffer in one ram
// ----------------------------------------------------------------------------
// usage:
//   a command transaction is taken when start is high and busy is low.
//   insert gives no result unless the store is full,
//   in which case a refusal result follows in the next cycle.
//   backspace gives its deletion report in the next cycle.
//   a cursor move copies min(k, available) characters, one per cycle, across
//   the gap through the ram (each one read, then written from the registered
//   read data, overlapped) while busy, then reads one window character per
//   cycle, up to WINDOW, each result in the cycle after its ram read.
//   a move with nothing left of the cursor gives a single empty result.
//   results appear on rsp_* for exactly one cycle marked by rsp_strobe;
//   the receiver cannot stall, so none is held back.
//   reset empties the text; the ram contents need no clearing.
// ----------------------------------------------------------------------------
module cursor_text_buffer_top
   import ctb_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int WINDOW   = WINDOW_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [OPCODE_W-1:0] req_opcode,
   input  logic [CHAR_W-1:0]   req_char_in,
   input  logic [STEP_W-1:0]   req_step_count,
   output logic                rsp_strobe,
   output logic [KIND_W-1:0]   rsp_kind,
   output logic [STEP_W-1:0]   rsp_deleted_count,
   output logic [CHAR_W-1:0]   rsp_text_char,
   output logic                rsp_char_valid,
   output logic                rsp_last
);

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int LEN_W  = $clog2(CAPACITY + 1);
   localparam int WIN_W  = $clog2(WINDOW + 1);
   localparam int CMP_W  = (STEP_W > LEN_W) ? STEP_W : LEN_W;
   localparam int WCMP_W = (WIN_W > LEN_W) ? WIN_W : LEN_W;
   localparam logic [LEN_W-1:0]  CAP_L   = LEN_W'(CAPACITY);
   localparam logic [LEN_W:0]    CAP_X   = (LEN_W + 1)'(CAPACITY);
   localparam logic [WCMP_W-1:0] WIN_X   = WCMP_W'(WINDOW);
   localparam logic [WIN_W-1:0]  WIN_L   = WIN_W'(WINDOW);

   state_type          state_ff, state_in;
   logic [LEN_W-1:0]   left_ff, left_in;
   logic [LEN_W-1:0]   right_ff, right_in;
   logic               dir_right_ff, dir_right_in;
   logic [LEN_W-1:0]   rem_ff, rem_in;
   logic               wr_pend_ff, wr_pend_in;
   logic [ADDR_W-1:0]  wr_addr_ff, wr_addr_in;
   logic [WIN_W-1:0]   win_rem_ff, win_rem_in;
   logic [ADDR_W-1:0]  win_addr_ff, win_addr_in;

   logic               strobe_ff, strobe_in;
   kind_type           kind_ff, kind_in;
   logic [STEP_W-1:0]  deleted_ff, deleted_in;
   logic               char_sel_ff, char_sel_in;
   logic               last_ff, last_in;

   logic               ram_we;
   logic [ADDR_W-1:0]  ram_waddr;
   logic [CHAR_W-1:0]  ram_wdata;
   logic               ram_re;
   logic [ADDR_W-1:0]  ram_raddr;
   logic [CHAR_W-1:0]  ram_rdata;

   logic [CMP_W-1:0]   step_x;
   logic [CMP_W-1:0]   left_x;
   logic [CMP_W-1:0]   right_x;
   logic [CMP_W-1:0]   del_n;
   logic [CMP_W-1:0]   mvl_n;
   logic [CMP_W-1:0]   mvr_n;
   logic [WCMP_W-1:0]  left_w;
   logic [WIN_W-1:0]   win_n;
   logic               full;

   ctb_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         left_ff    <= '0;
         right_ff   <= '0;
         wr_pend_ff <= 1'b0;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         left_ff    <= left_in;
         right_ff   <= right_in;
         wr_pend_ff <= wr_pend_in;
         strobe_ff  <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      dir_right_ff <= dir_right_in;
      rem_ff       <= rem_in;
      wr_addr_ff   <= wr_addr_in;
      win_rem_ff   <= win_rem_in;
      win_addr_ff  <= win_addr_in;
      kind_ff      <= kind_in;
      deleted_ff   <= deleted_in;
      char_sel_ff  <= char_sel_in;
      last_ff      <= last_in;
   end

   always_comb begin
      step_x  = CMP_W'(req_step_count);
      left_x  = CMP_W'(left_ff);
      right_x = CMP_W'(right_ff);
      del_n   = (step_x < left_x) ? step_x : left_x;
      mvl_n   = del_n;
      mvr_n   = (step_x < right_x) ? step_x : right_x;
      left_w  = WCMP_W'(left_ff);
      win_n   = (left_w < WIN_X) ? WIN_W'(left_ff) : WIN_L;
      full    = ({1'b0, left_ff} + {1'b0, right_ff}) >= CAP_X;
   end

   always_comb begin
      state_in     = state_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      dir_right_in = dir_right_ff;
      rem_in       = rem_ff;
      wr_pend_in   = 1'b0;
      wr_addr_in   = wr_addr_ff;
      win_rem_in   = win_rem_ff;
      win_addr_in  = win_addr_ff;
      strobe_in    = 1'b0;
      kind_in      = kind_ff;
      deleted_in   = deleted_ff;
      char_sel_in  = 1'b0;
      last_in      = last_ff;
      ram_we       = 1'b0;
      ram_waddr    = wr_addr_ff;
      ram_wdata    = ram_rdata;
      ram_re       = 1'b0;
      ram_raddr    = win_addr_ff;

      if (wr_pend_ff) begin
         ram_we    = 1'b1;
         ram_waddr = wr_addr_ff;
         ram_wdata = ram_rdata;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (opcode_type'(req_opcode))
                  OP_INSERT: begin
                     if (full) begin
                        strobe_in  = 1'b1;
                        kind_in    = KIND_FULL;
                        deleted_in = '0;
                        last_in    = 1'b1;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = left_ff[ADDR_W-1:0];
                        ram_wdata = req_char_in;
                        left_in   = left_ff + LEN_W'(1);
                     end
                  end
                  OP_BACKSPACE: begin
                     left_in    = left_ff - LEN_W'(del_n);
                     strobe_in  = 1'b1;
                     kind_in    = KIND_DELETE;
                     deleted_in = STEP_W'(del_n);
                     last_in    = 1'b1;
                  end
                  OP_LEFT: begin
                     dir_right_in = 1'b0;
                     rem_in       = LEN_W'(mvl_n);
                     state_in     = ST_MOVE;
                  end
                  OP_RIGHT: begin
                     dir_right_in = 1'b1;
                     rem_in       = LEN_W'(mvr_n);
                     state_in     = ST_MOVE;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_MOVE: begin
            if (rem_ff != '0) begin
               ram_re     = 1'b1;
               wr_pend_in = 1'b1;
               rem_in     = rem_ff - LEN_W'(1);
               if (dir_right_ff) begin
                  ram_raddr  = ADDR_W'(CAP_L - right_ff);
                  wr_addr_in = left_ff[ADDR_W-1:0];
                  right_in   = right_ff - LEN_W'(1);
                  left_in    = left_ff + LEN_W'(1);
               end else begin
                  ram_raddr  = ADDR_W'(left_ff - LEN_W'(1));
                  wr_addr_in = ADDR_W'(CAP_L - right_ff - LEN_W'(1));
                  left_in    = left_ff - LEN_W'(1);
                  right_in   = right_ff + LEN_W'(1);
               end
            end else if (left_ff == '0) begin
               strobe_in  = 1'b1;
               kind_in    = KIND_CHAR;
               deleted_in = '0;
               last_in    = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               win_rem_in  = win_n;
               win_addr_in = ADDR_W'(left_ff - LEN_W'(win_n));
               state_in    = ST_WINDOW;
            end
         end
         ST_WINDOW: begin
            ram_re      = 1'b1;
            ram_raddr   = win_addr_ff;
            win_addr_in = win_addr_ff + ADDR_W'(1);
            win_rem_in  = win_rem_ff - WIN_W'(1);
            strobe_in   = 1'b1;
            kind_in     = KIND_CHAR;
            deleted_in  = '0;
            char_sel_in = 1'b1;
            last_in     = (win_rem_ff == WIN_W'(1));
            if (win_rem_ff == WIN_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_strobe        = strobe_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_deleted_count = deleted_ff;
   assign rsp_text_char     = char_sel_ff ? ram_rdata : '0;
   assign rsp_char_valid    = char_sel_ff;
   assign rsp_last          = last_ff;

endmodule
